// File: rtl/wnms_pkg.sv
package wnms_pkg;

  // Fixed field widths
  localparam int CELL_W  = 12;
  localparam int SLOT_W  = 3;
  localparam int CNT_W   = 3;
  localparam int AGENT_W = 20;
  localparam int DATA_W  = 32;

  // Neighborhood shape: slot 0 is stay, slots 1..MAX_NB are neighbors
  localparam int MAX_NB  = 6;
  localparam int ROW_LEN = MAX_NB + 1;

  // Request action codes
  localparam logic [1:0] OP_WEIGHT   = 2'd0;
  localparam logic [1:0] OP_NEIGHBOR = 2'd1;
  localparam logic [1:0] OP_COUNT    = 2'd2;
  localparam logic [1:0] OP_MOVE     = 2'd3;

  // Move status codes
  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_MOVED   = 2'd1;
  localparam logic [1:0] ST_ICED    = 2'd2;
  localparam logic [1:0] ST_ILLEGAL = 2'd3;

  // Configuration register indexes
  localparam logic CFG_MOVE_PROB = 1'b0;
  localparam logic CFG_ICE_EN    = 1'b1;

  typedef struct packed {
    logic [1:0]         action;
    logic [CELL_W-1:0]  cell_req;
    logic [SLOT_W-1:0]  slot;
    logic [DATA_W-1:0]  write_value;
    logic [AGENT_W-1:0] agent_id;
    logic               alive;
    logic [DATA_W-1:0]  move_draw;
    logic [DATA_W-1:0]  pick_draw;
  } req_t;

  typedef struct packed {
    logic [AGENT_W-1:0] result_agent;
    logic [1:0]         move_status;
    logic [CELL_W-1:0]  from_cell;
    logic [CELL_W-1:0]  to_cell;
    logic               success;
  } res_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic [1:0]         op;
    logic               live;   // write in range, or move attempted
    logic [CELL_W-1:0]  cell_addr;
    logic [SLOT_W-1:0]  slot;
    logic [DATA_W-1:0]  wval;
    logic [AGENT_W-1:0] agent;
    logic [DATA_W-1:0]  pick;
  } cmd_t;

endpackage

// File: rtl/wnms_front.sv
module wnms_front #(
  parameter int NUM_CELLS = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  wnms_pkg::req_t              req,
  input  logic [wnms_pkg::DATA_W-1:0] move_probability,
  output logic                        cmd_valid,
  output wnms_pkg::cmd_t              cmd,
  input  logic                        queue_full
);

  localparam logic [20:0] NC = 21'(NUM_CELLS);

  logic           cell_ok;
  logic           live;
  logic           take;
  logic           push;
  wnms_pkg::cmd_t cmd_next;

  // Classify the incoming request
  assign cell_ok = 21'(req.cell_req) < NC;

  always_comb begin
    case (req.action)
      wnms_pkg::OP_WEIGHT:
        live = cell_ok && (req.slot <= wnms_pkg::SLOT_W'(wnms_pkg::MAX_NB));
      wnms_pkg::OP_NEIGHBOR:
        live = cell_ok && (req.slot < wnms_pkg::SLOT_W'(wnms_pkg::MAX_NB));
      wnms_pkg::OP_COUNT:
        live = cell_ok;
      default:
        live = cell_ok && req.alive && (req.move_draw < move_probability);
    endcase
  end

  always_comb begin
    cmd_next.op        = req.action;
    cmd_next.live      = live;
    cmd_next.cell_addr = req.cell_req;
    cmd_next.slot      = req.slot;
    cmd_next.wval      = req.write_value;
    cmd_next.agent     = req.agent_id;
    cmd_next.pick      = req.pick_draw;
  end

  // One holding stage toward the queue
  assign push      = cmd_valid && !queue_full;
  assign req_stall = cmd_valid && queue_full;
  assign take      = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (take) begin
      cmd_valid <= 1'b1;
    end else if (push) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd <= cmd_next;
    end
  end

endmodule

// File: rtl/wnms_queue.sv
module wnms_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  input  wnms_pkg::cmd_t push_cmd,
  output logic           full,
  output logic           head_valid,
  output wnms_pkg::cmd_t head,
  input  logic           pop
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  wnms_pkg::cmd_t   entry [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full       = count == CW'(DEPTH);
  assign head_valid = count != '0;
  assign head       = entry[rd_ptr];
  assign do_push    = push_valid && !full;
  assign do_pop     = pop && head_valid;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

endmodule

// File: rtl/wnms_back.sv
module wnms_back #(
  parameter int NUM_CELLS   = 4096,
  parameter int WEIGHT_BITS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  wnms_pkg::cmd_t head,
  output logic           pop,
  input  logic           ice_check_enabled,
  output logic           res_valid,
  input  logic           res_stall,
  output wnms_pkg::res_t res
);

  localparam int ROWS = (NUM_CELLS < 4096) ? NUM_CELLS : 4096;
  localparam int RW   = $clog2(ROWS);
  localparam int IW   = $clog2(NUM_CELLS);
  localparam int NAW  = $clog2(ROWS * wnms_pkg::MAX_NB);
  localparam int PW   = wnms_pkg::DATA_W + WEIGHT_BITS;
  localparam int UW   = wnms_pkg::DATA_W + wnms_pkg::CNT_W;
  localparam logic [wnms_pkg::DATA_W:0] NC = (wnms_pkg::DATA_W + 1)'(NUM_CELLS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_SEL  = 3'd2;
  localparam logic [2:0] S_NB   = 3'd3;
  localparam logic [2:0] S_ICE  = 3'd4;
  localparam logic [2:0] S_PUT  = 3'd5;

  logic [2:0]                     state;
  logic [2:0]                     state_next;

  // Request being worked on
  logic [wnms_pkg::AGENT_W-1:0]   cur_agent;
  logic [wnms_pkg::CELL_W-1:0]    cur_cell;
  logic [wnms_pkg::DATA_W-1:0]    cur_pick;
  logic [1:0]                     status;
  logic [wnms_pkg::CELL_W-1:0]    to_cell;

  // Memory read data
  logic [WEIGHT_BITS-1:0]         w_rd [wnms_pkg::ROW_LEN];
  logic [wnms_pkg::CNT_W-1:0]     cnt_rd;
  logic [IW:0]                    nb_rd;
  logic                           ice_rd;

  logic [wnms_pkg::CNT_W-1:0]     cnt_mem [ROWS];
  logic [IW:0]                    nb_mem  [ROWS * wnms_pkg::MAX_NB];
  logic                           ice_mem [NUM_CELLS];

  // Products of the scaling step
  logic [WEIGHT_BITS-1:0]         total;
  logic [PW-1:0]                  prod_w;
  logic [UW-1:0]                  prod_c;
  logic [WEIGHT_BITS-1:0]         scaled_hi;
  logic [wnms_pkg::CNT_W-1:0]     uni_slot;
  logic                           flat;

  logic [wnms_pkg::SLOT_W-1:0]    sel;
  logic                           sel_hit;
  logic [wnms_pkg::SLOT_W-1:0]    first;
  logic                           found;

  logic                           start_move;
  logic                           wr_live;
  logic [RW-1:0]                  head_row;
  logic [NAW-1:0]                 nb_wr_addr;
  logic [NAW-1:0]                 nb_rd_addr;
  logic [wnms_pkg::CNT_W-1:0]     cnt_sat;
  logic                           nb_ok;
  logic                           out_free;

  assign pop        = (state == S_IDLE) && head_valid;
  assign wr_live    = pop && head.live;
  assign start_move = pop && (head.op == wnms_pkg::OP_MOVE) && head.live;
  assign head_row   = head.cell_addr[RW-1:0];
  assign out_free   = !res_valid || !res_stall;

  // Write-side address and data prep
  assign nb_wr_addr = NAW'(head_row) * NAW'(wnms_pkg::MAX_NB) + NAW'(head.slot);
  assign nb_ok      = {1'b0, head.wval} < NC;
  assign cnt_sat    = (head.wval[wnms_pkg::CNT_W-1:0] > wnms_pkg::CNT_W'(wnms_pkg::MAX_NB))
                      ? wnms_pkg::CNT_W'(wnms_pkg::MAX_NB)
                      : head.wval[wnms_pkg::CNT_W-1:0];

  // Weight banks, one per slot, so all slots of a row are read together
  for (genvar b = 0; b < wnms_pkg::ROW_LEN; b++) begin : g_bank
    logic [WEIGHT_BITS-1:0] mem [ROWS];

    always_ff @(posedge clk) begin
      if (wr_live && (head.op == wnms_pkg::OP_WEIGHT) &&
          (head.slot == wnms_pkg::SLOT_W'(b))) begin
        mem[head_row] <= head.wval[WEIGHT_BITS-1:0];
      end
      if (start_move) begin
        w_rd[b] <= mem[head_row];
      end
    end
  end

  // Neighbor count per cell
  always_ff @(posedge clk) begin
    if (wr_live && (head.op == wnms_pkg::OP_COUNT)) begin
      cnt_mem[head_row] <= cnt_sat;
    end
    if (start_move) begin
      cnt_rd <= cnt_mem[head_row];
    end
  end

  // Neighbor table: in-range flag over the cell number
  assign nb_rd_addr = NAW'(cur_cell[RW-1:0]) * NAW'(wnms_pkg::MAX_NB) + NAW'(sel - 1'b1);

  always_ff @(posedge clk) begin
    if (wr_live && (head.op == wnms_pkg::OP_NEIGHBOR)) begin
      nb_mem[nb_wr_addr] <= {nb_ok, head.wval[IW-1:0]};
    end
    if ((state == S_SEL) && sel_hit) begin
      nb_rd <= nb_mem[nb_rd_addr];
    end
  end

  // Ice flags, looked up at the chosen neighbor
  always_ff @(posedge clk) begin
    if (wr_live && (head.op == wnms_pkg::OP_COUNT)) begin
      ice_mem[IW'(head.cell_addr)] <= head.wval[wnms_pkg::CNT_W];
    end
    if (state == S_NB) begin
      ice_rd <= ice_mem[nb_rd[IW-1:0]];
    end
  end

  // Row total and the two scaled picks
  always_comb begin
    total = '0;
    for (int i = 0; i < wnms_pkg::ROW_LEN; i++) begin
      if (cnt_rd == wnms_pkg::CNT_W'(i)) begin
        total = w_rd[i];
      end
    end
  end

  assign prod_w = PW'(cur_pick) * PW'(total);
  assign prod_c = UW'(cur_pick) * UW'(cnt_rd);

  always_ff @(posedge clk) begin
    if (state == S_RD) begin
      scaled_hi <= prod_w[PW-1:wnms_pkg::DATA_W];
      uni_slot  <= prod_c[UW-1:wnms_pkg::DATA_W];
      flat      <= w_rd[0] == total;
    end
  end

  // First slot whose weight exceeds the scaled pick
  always_comb begin
    first = '0;
    found = 1'b0;
    for (int i = wnms_pkg::ROW_LEN - 1; i >= 0; i--) begin
      if ((wnms_pkg::CNT_W'(i) <= cnt_rd) && (scaled_hi < w_rd[i])) begin
        first = wnms_pkg::SLOT_W'(i);
        found = 1'b1;
      end
    end
  end

  assign sel     = flat ? uni_slot : first;
  assign sel_hit = (flat || found) && (sel != '0);

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (pop && (head.op == wnms_pkg::OP_MOVE)) begin
          state_next = head.live ? S_RD : S_PUT;
        end
      end
      S_RD:  state_next = S_SEL;
      S_SEL: state_next = sel_hit ? S_NB : S_PUT;
      S_NB:  state_next = nb_rd[IW] ? S_ICE : S_PUT;
      S_ICE: state_next = S_PUT;
      S_PUT: state_next = out_free ? S_IDLE : S_PUT;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Per-request context and outcome
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (pop) begin
          cur_agent <= head.agent;
          cur_cell  <= head.cell_addr;
          cur_pick  <= head.pick;
          status    <= wnms_pkg::ST_NONE;
          to_cell   <= '0;
        end
      end
      S_NB: begin
        if (nb_rd[IW]) begin
          to_cell <= wnms_pkg::CELL_W'(nb_rd[IW-1:0]);
        end else begin
          status  <= wnms_pkg::ST_ILLEGAL;
        end
      end
      S_ICE: begin
        status <= (ice_check_enabled && ice_rd) ? wnms_pkg::ST_ICED : wnms_pkg::ST_MOVED;
      end
      default: begin
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((state == S_PUT) && out_free) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_PUT) && out_free) begin
      res.result_agent <= cur_agent;
      res.move_status  <= status;
      res.from_cell    <= cur_cell;
      res.to_cell      <= to_cell;
      res.success      <= (status == wnms_pkg::ST_MOVED) || (status == wnms_pkg::ST_ICED);
    end
  end

endmodule

// File: rtl/weighted_neighbor_move_select.sv
// Weighted neighbor move selection.
// Request channel (req_valid/req_stall/req) carries table writes and move
// requests in one ordered stream. Writes load the per-cell weight rows,
// neighbor entries, and count/ice words; they produce no result. Each move
// request produces exactly one result on res_valid/res_stall/res.
// Configuration (cfg_write/cfg_index/cfg_data) sets the move probability and
// the ice check; write it only while no request is in flight.
// Flow: a request passes the front register and a two-entry queue to the back
// unit, which takes a write in its idle state. A move not attempted goes to
// the result load; an attempted move follows the chain of dependent memory
// reads (weight row, then neighbor entry, then ice flag, ending early if no
// neighbor slot is chosen or the entry is out of range) and the result load.
// The back unit takes one write per cycle while idle, none during a move.
// Reset clears the control state and the two configuration registers; table
// contents are undefined until written. While res_stall is high the result is
// held, and the queue and front keep taking requests until they fill, after
// which req_stall rises.
module weighted_neighbor_move_select #(
  parameter int NUM_CELLS   = 4096,
  parameter int WEIGHT_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  wnms_pkg::req_t              req,
  output logic                        res_valid,
  input  logic                        res_stall,
  output wnms_pkg::res_t              res,
  input  logic                        cfg_write,
  input  logic                        cfg_index,
  input  logic [wnms_pkg::DATA_W-1:0] cfg_data
);

  logic [wnms_pkg::DATA_W-1:0] move_probability;
  logic                        ice_check_enabled;

  logic                        cmd_valid;
  wnms_pkg::cmd_t              cmd;
  logic                        queue_full;
  logic                        head_valid;
  wnms_pkg::cmd_t              head;
  logic                        pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      move_probability  <= '0;
      ice_check_enabled <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        wnms_pkg::CFG_MOVE_PROB: move_probability  <= cfg_data;
        wnms_pkg::CFG_ICE_EN:    ice_check_enabled <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  wnms_front #(
    .NUM_CELLS (NUM_CELLS)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_valid),
    .req_stall        (req_stall),
    .req              (req),
    .move_probability (move_probability),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .queue_full       (queue_full)
  );

  wnms_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (cmd_valid),
    .push_cmd   (cmd),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  wnms_back #(
    .NUM_CELLS   (NUM_CELLS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .head_valid        (head_valid),
    .head              (head),
    .pop               (pop),
    .ice_check_enabled (ice_check_enabled),
    .res_valid         (res_valid),
    .res_stall         (res_stall),
    .res               (res)
  );

endmodule

// File: dv/weighted_neighbor_move_select_test.sv
module weighted_neighbor_move_select_test;

  localparam int unsigned CELL_COUNT = 1 << wnms_pkg::CELL_W;
  localparam int unsigned POOL = 12;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned ITEMS_PER_PHASE = 40;
  localparam int unsigned SQUEEZE_AT = 230;
  localparam int unsigned SQUEEZE_CYCLES = 150;

  // Table mirror and expected move results
  class move_scoreboard;
    bit [wnms_pkg::DATA_W-1:0] weight_rows [CELL_COUNT][wnms_pkg::ROW_LEN];
    bit [wnms_pkg::DATA_W-1:0] neighbor_cells [CELL_COUNT][wnms_pkg::MAX_NB];
    bit [wnms_pkg::CNT_W-1:0]  cell_degree [CELL_COUNT];
    bit                        cell_iced [CELL_COUNT];
    bit [wnms_pkg::DATA_W-1:0] move_prob;
    bit                        ice_on;
    wnms_pkg::res_t            awaited_moves [$];
    int unsigned               mismatches;

    function void apply_register(logic idx, logic [wnms_pkg::DATA_W-1:0] data);
      if (idx == wnms_pkg::CFG_MOVE_PROB) move_prob = data;
      else ice_on = data[0];
    endfunction

    // Roulette pick over the cumulative row; -1 when no slot qualifies
    function int pick_slot(logic [wnms_pkg::CELL_W-1:0] cell_no,
                           logic [wnms_pkg::DATA_W-1:0] pick);
      bit [wnms_pkg::CNT_W-1:0]  cnt;
      bit [wnms_pkg::DATA_W-1:0] total;
      bit [63:0]                 scaled;
      cnt = cell_degree[cell_no];
      total = weight_rows[cell_no][cnt];
      // flat row: uniform choice over the count
      if (weight_rows[cell_no][0] == total)
        return int'((64'(pick) * 64'(cnt)) >> 32);
      scaled = 64'(pick) * 64'(total);
      for (int i = 0; i <= int'(cnt); i++)
        if (scaled < {weight_rows[cell_no][i], 32'h0}) return i;
      return -1;
    endfunction

    function void note_request(wnms_pkg::req_t r);
      bit [wnms_pkg::CNT_W-1:0]  cnt;
      int                        choice;
      bit [wnms_pkg::DATA_W-1:0] nb;
      wnms_pkg::res_t            want;
      case (r.action)
        wnms_pkg::OP_WEIGHT: begin
          if (r.slot <= wnms_pkg::MAX_NB) weight_rows[r.cell_req][r.slot] = r.write_value;
        end
        wnms_pkg::OP_NEIGHBOR: begin
          if (r.slot < wnms_pkg::MAX_NB) neighbor_cells[r.cell_req][r.slot] = r.write_value;
        end
        wnms_pkg::OP_COUNT: begin
          // count saturates at the neighbor maximum
          cnt = r.write_value[2:0];
          if (cnt > wnms_pkg::MAX_NB) cnt = wnms_pkg::CNT_W'(wnms_pkg::MAX_NB);
          cell_degree[r.cell_req] = cnt;
          cell_iced[r.cell_req] = r.write_value[3];
        end
        default: begin
          want = '0;
          want.result_agent = r.agent_id;
          want.from_cell = r.cell_req;
          want.move_status = wnms_pkg::ST_NONE;
          if (r.alive && r.move_draw < move_prob) begin
            choice = pick_slot(r.cell_req, r.pick_draw);
            if (choice > 0) begin
              nb = neighbor_cells[r.cell_req][choice - 1];
              if (nb >= CELL_COUNT) begin
                want.move_status = wnms_pkg::ST_ILLEGAL;
              end else begin
                want.to_cell = nb[wnms_pkg::CELL_W-1:0];
                want.move_status = (ice_on && cell_iced[nb[wnms_pkg::CELL_W-1:0]]) ?
                                   wnms_pkg::ST_ICED : wnms_pkg::ST_MOVED;
                want.success = 1'b1;
              end
            end
          end
          awaited_moves = {awaited_moves, want};
        end
      endcase
    endfunction

    function void check_result(wnms_pkg::res_t got);
      wnms_pkg::res_t want;
      if (awaited_moves.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: agent=%h status=%0d from=%h to=%h ok=%0d",
                   got.result_agent, got.move_status, got.from_cell, got.to_cell,
                   got.success);
        return;
      end
      want = awaited_moves.pop_front();
      if (got.result_agent !== want.result_agent || got.move_status !== want.move_status ||
          got.from_cell !== want.from_cell || got.to_cell !== want.to_cell ||
          got.success !== want.success) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp a=%h s=%0d f=%h t=%h ok=%0d / got a=%h s=%0d f=%h t=%h ok=%0d",
                   want.result_agent, want.move_status, want.from_cell, want.to_cell,
                   want.success, got.result_agent, got.move_status, got.from_cell,
                   got.to_cell, got.success);
      end
    endfunction

    function int unsigned outstanding();
      return awaited_moves.size();
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        req_valid = 1'b0;
  logic                        req_stall;
  wnms_pkg::req_t              req = '0;
  logic                        res_valid;
  logic                        res_stall = 1'b0;
  wnms_pkg::res_t              res;
  logic                        cfg_write = 1'b0;
  logic                        cfg_index = 1'b0;
  logic [wnms_pkg::DATA_W-1:0] cfg_data = '0;

  move_scoreboard              sb;
  logic [wnms_pkg::CELL_W-1:0] pool_cells [POOL];
  logic [wnms_pkg::DATA_W-1:0] cur_prob = '0;
  bit                          idle_on = 1'b1;
  int unsigned                 sent_count = 0;
  int unsigned                 cycle_count = 0;

  weighted_neighbor_move_select dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Accepted requests feed the predictor; accepted results get checked
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) sb.note_request(req);
      if (res_valid && !res_stall) sb.check_result(res);
    end
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int unsigned idle_len();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  function automatic bit in_pool(logic [wnms_pkg::CELL_W-1:0] cell_no, int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      if (pool_cells[i] == cell_no) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [wnms_pkg::DATA_W-1:0] weight_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Neighbor entries of pool cells point at pool cells or at no cell
  function automatic logic [wnms_pkg::DATA_W-1:0] nb_value();
    case ($urandom_range(0, 9))
      7: return CELL_COUNT;
      8: return '1;
      9: return $urandom_range(CELL_COUNT + 1, 32'hFFFF_FFFE);
      default: return wnms_pkg::DATA_W'(pool_cells[$urandom_range(0, POOL - 1)]);
    endcase
  endfunction

  function automatic wnms_pkg::req_t make_write(logic [1:0] op,
                                                logic [wnms_pkg::CELL_W-1:0] cell_no,
                                                logic [wnms_pkg::SLOT_W-1:0] slot,
                                                logic [wnms_pkg::DATA_W-1:0] value);
    wnms_pkg::req_t r;
    r.action = op;
    r.cell_req = cell_no;
    r.slot = slot;
    r.write_value = value;
    r.agent_id = wnms_pkg::AGENT_W'($urandom);
    r.alive = 1'($urandom);
    r.move_draw = $urandom;
    r.pick_draw = $urandom;
    return r;
  endfunction

  function automatic wnms_pkg::req_t make_move(logic [wnms_pkg::CELL_W-1:0] cell_no,
                                               logic [wnms_pkg::AGENT_W-1:0] agent,
                                               logic [wnms_pkg::DATA_W-1:0] mdraw,
                                               logic [wnms_pkg::DATA_W-1:0] pick,
                                               logic alive);
    wnms_pkg::req_t r;
    r.action = wnms_pkg::OP_MOVE;
    r.cell_req = cell_no;
    r.slot = wnms_pkg::SLOT_W'($urandom);
    r.write_value = $urandom;
    r.agent_id = agent;
    r.alive = alive;
    r.move_draw = mdraw;
    r.pick_draw = pick;
    return r;
  endfunction

  // Offer one request, optionally after a gap, and hold it until taken
  task automatic send_request(input wnms_pkg::req_t item);
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 99) < 35) ? idle_len() : 0;
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req = item;
    req_valid = 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [wnms_pkg::DATA_W-1:0] data);
    cfg_index = idx;
    cfg_data = data;
    cfg_write = 1'b1;
    @(negedge clk);
    cfg_write = 1'b0;
    sb.apply_register(idx, data);
    if (idx == wnms_pkg::CFG_MOVE_PROB) cur_prob = data;
  endtask

  // Drain all results, then give trailing writes time to land
  task automatic settle();
    req_valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  // One cumulative row: rising, flat, arbitrary, or rising with many ties
  task automatic write_row(input logic [wnms_pkg::CELL_W-1:0] cell_no);
    logic [wnms_pkg::DATA_W-1:0] acc;
    int unsigned                 mode;
    mode = $urandom_range(0, 3);
    acc = (mode == 1) ? weight_value() : (mode == 3) ? '0 : $urandom_range(0, 1000);
    for (int s = 0; s < wnms_pkg::ROW_LEN; s++) begin
      case (mode)
        0: begin
          send_request(make_write(wnms_pkg::OP_WEIGHT, cell_no, wnms_pkg::SLOT_W'(s), acc));
          if ($urandom_range(0, 4) != 0) acc += $urandom_range(1, 32'h1FFF_FFFF);
        end
        1: send_request(make_write(wnms_pkg::OP_WEIGHT, cell_no, wnms_pkg::SLOT_W'(s), acc));
        2: send_request(make_write(wnms_pkg::OP_WEIGHT, cell_no, wnms_pkg::SLOT_W'(s),
                                   weight_value()));
        default: begin
          send_request(make_write(wnms_pkg::OP_WEIGHT, cell_no, wnms_pkg::SLOT_W'(s), acc));
          acc += $urandom_range(0, 3);
        end
      endcase
    end
  endtask

  task automatic init_cell(input logic [wnms_pkg::CELL_W-1:0] cell_no);
    write_row(cell_no);
    for (int k = 0; k < wnms_pkg::MAX_NB; k++)
      send_request(make_write(wnms_pkg::OP_NEIGHBOR, cell_no, wnms_pkg::SLOT_W'(k),
                              nb_value()));
    send_request(make_write(wnms_pkg::OP_COUNT, cell_no, '0, $urandom));
  endtask

  task automatic random_phase();
    int unsigned                 kind;
    logic [wnms_pkg::CELL_W-1:0] target;
    logic [wnms_pkg::SLOT_W-1:0] slot;
    logic [wnms_pkg::DATA_W-1:0] mdraw;
    logic [wnms_pkg::DATA_W-1:0] pick;
    for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
      if ($urandom_range(0, 39) == 0) idle_on = !idle_on;
      kind = $urandom_range(0, 99);
      target = pool_cells[$urandom_range(0, POOL - 1)];
      if (kind < 62) begin
        // well-formed move request on a loaded cell
        mdraw = (cur_prob != 0 && $urandom_range(0, 9) < 8) ?
                $urandom_range(0, cur_prob - 1) : $urandom;
        case ($urandom_range(0, 9))
          0: pick = '0;
          1: pick = '1;
          default: pick = $urandom;
        endcase
        send_request(make_move(target, wnms_pkg::AGENT_W'($urandom), mdraw, pick,
                               $urandom_range(0, 9) != 0));
      end else if (kind < 74) begin
        send_request(make_write(wnms_pkg::OP_WEIGHT, target, wnms_pkg::SLOT_W'($urandom),
                                weight_value()));
      end else if (kind < 82) begin
        slot = wnms_pkg::SLOT_W'($urandom);
        send_request(make_write(wnms_pkg::OP_NEIGHBOR, target, slot,
                                (slot < wnms_pkg::MAX_NB) ? nb_value() : $urandom));
      end else if (kind < 88) begin
        send_request(make_write(wnms_pkg::OP_COUNT, target, wnms_pkg::SLOT_W'($urandom),
                                $urandom));
      end else if (kind < 93) begin
        // noise: writes to cells no move ever reads
        do target = wnms_pkg::CELL_W'($urandom); while (in_pool(target, POOL));
        send_request(make_write(2'($urandom_range(wnms_pkg::OP_WEIGHT, wnms_pkg::OP_COUNT)),
                                target, wnms_pkg::SLOT_W'($urandom), $urandom));
      end else begin
        write_row(target);
      end
    end
  endtask

  // Result side: random stall bursts plus one long hold-off to back up the block
  initial begin : result_side
    int unsigned burst_left;
    int unsigned hold_left;
    bit          squeezed;
    burst_left = 0;
    hold_left = 0;
    squeezed = 1'b0;
    forever begin
      @(negedge clk);
      if (!squeezed && sent_count >= SQUEEZE_AT) begin
        squeezed = 1'b1;
        hold_left = SQUEEZE_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall = 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        res_stall = 1'b1;
      end else if (idle_on && $urandom_range(0, 99) < 25) begin
        burst_left = idle_len() - 1;
        res_stall = 1'b1;
      end else begin
        res_stall = 1'b0;
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL weighted_neighbor_move_select");
    $finish;
  end

  initial begin
    logic [wnms_pkg::CELL_W-1:0] c;
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    write_register(wnms_pkg::CFG_MOVE_PROB, '0);
    write_register(wnms_pkg::CFG_ICE_EN, '0);

    // Loaded cells: both ends of the grid plus random ones
    pool_cells[0] = '0;
    pool_cells[1] = '1;
    for (int unsigned i = 2; i < POOL; i++) begin
      do c = wnms_pkg::CELL_W'($urandom_range(1, CELL_COUNT - 2)); while (in_pool(c, i));
      pool_cells[i] = c;
    end

    // Cell 0: strictly rising row, a missing neighbor in slots 2 and 3
    for (int s = 0; s < wnms_pkg::ROW_LEN; s++)
      send_request(make_write(wnms_pkg::OP_WEIGHT, '0, wnms_pkg::SLOT_W'(s),
                              (s == 0) ? 5 : 10 * s));
    send_request(make_write(wnms_pkg::OP_NEIGHBOR, '0, 3'd0, CELL_COUNT - 1));
    send_request(make_write(wnms_pkg::OP_NEIGHBOR, '0, 3'd1, CELL_COUNT));
    send_request(make_write(wnms_pkg::OP_NEIGHBOR, '0, 3'd2, '1));
    for (int k = 3; k < wnms_pkg::MAX_NB; k++)
      send_request(make_write(wnms_pkg::OP_NEIGHBOR, '0, wnms_pkg::SLOT_W'(k),
                              wnms_pkg::DATA_W'(pool_cells[k - 1])));
    send_request(make_write(wnms_pkg::OP_COUNT, '0, '0, 32'hFFFF_FFF6));
    // Last cell: flat row, count of 7 saturates, iced
    for (int s = 0; s < wnms_pkg::ROW_LEN; s++)
      send_request(make_write(wnms_pkg::OP_WEIGHT, '1, wnms_pkg::SLOT_W'(s), '1));
    for (int k = 0; k < wnms_pkg::MAX_NB; k++)
      send_request(make_write(wnms_pkg::OP_NEIGHBOR, '1, wnms_pkg::SLOT_W'(k), nb_value()));
    send_request(make_write(wnms_pkg::OP_COUNT, '1, '0, 32'h0000_000F));
    for (int unsigned i = 2; i < POOL; i++) init_cell(pool_cells[i]);

    // Directed: zero probability never moves
    send_request(make_move('0, '0, '0, 32'h2000_0000, 1'b1));
    settle();
    write_register(wnms_pkg::CFG_MOVE_PROB, '1);
    write_register(wnms_pkg::CFG_ICE_EN, '1);
    // stay slot, last slot, iced target, missing neighbors, dead agent, draw at max
    send_request(make_move('0, '1, '0, '0, 1'b1));
    send_request(make_move('0, '0, '0, '1, 1'b1));
    send_request(make_move('0, '1, '0, 32'h2000_0000, 1'b1));
    send_request(make_move('0, '0, '0, 32'h4000_0000, 1'b1));
    send_request(make_move('0, '1, '0, 32'h6000_0000, 1'b1));
    send_request(make_move('0, '1, '0, 32'h2000_0000, 1'b0));
    send_request(make_move('0, '0, '1, 32'h2000_0000, 1'b1));
    // uniform choice on the flat row
    send_request(make_move('1, '1, 32'hFFFF_FFFE, '1, 1'b1));
    send_request(make_move('1, '0, '0, '0, 1'b1));
    send_request(make_move('1, '1, '0, 32'h3000_0000, 1'b1));
    // out-of-range slots are dropped
    send_request(make_write(wnms_pkg::OP_WEIGHT, '0, 3'd7, '0));
    send_request(make_write(wnms_pkg::OP_NEIGHBOR, '0, 3'd6, CELL_COUNT));
    send_request(make_write(wnms_pkg::OP_NEIGHBOR, '0, 3'd7, '1));
    send_request(make_move('0, '0, '0, 32'h2000_0000, 1'b1));
    // zero count, then a row that is not rising
    send_request(make_write(wnms_pkg::OP_COUNT, '0, '0, 32'hFFFF_FFF0));
    send_request(make_move('0, '1, '0, '1, 1'b1));
    send_request(make_write(wnms_pkg::OP_COUNT, '0, '0, 32'h0000_0006));
    send_request(make_write(wnms_pkg::OP_WEIGHT, '0, 3'd1, '0));
    send_request(make_move('0, '0, '0, 32'h2000_0000, 1'b1));
    settle();
    write_register(wnms_pkg::CFG_ICE_EN, 32'hFFFF_FFFE);
    // iced target passes with the check off
    send_request(make_write(wnms_pkg::OP_WEIGHT, '0, 3'd1, 32'd10));
    send_request(make_move('0, '1, '0, 32'h2000_0000, 1'b1));
    send_request(make_move('1, '0, '0, 32'h3000_0000, 1'b1));

    // Random phases over several register settings
    for (int p = 0; p < 4; p++) begin
      settle();
      write_register(wnms_pkg::CFG_MOVE_PROB,
                     p[0] ? 32'hFFFF_FFFF : $urandom_range(32'h4000_0000, 32'hFFFF_FFFE));
      write_register(wnms_pkg::CFG_ICE_EN,
                     p[0] ? ($urandom & 32'hFFFF_FFFE) : ($urandom | 32'h1));
      idle_on = (p != 2);
      random_phase();
    end

    req_valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("PASS weighted_neighbor_move_select");
    end else begin
      $display("FAIL weighted_neighbor_move_select");
    end
    $finish;
  end

endmodule
